FILE: sv/stu_pkg.sv
package stu_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int LINE_BITS   = 20;
   localparam int COLUMN_BITS = 16;
   localparam int LEN_BITS    = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int KW_COUNT    = 13;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]    LEN_MAX  = {LEN_BITS{1'b1}};

   // token kinds
   localparam logic [5:0] K_EOF      = 6'd0;
   localparam logic [5:0] K_ERR      = 6'd1;
   localparam logic [5:0] K_IDENT    = 6'd2;
   localparam logic [5:0] K_NUMBER   = 6'd3;
   localparam logic [5:0] K_COMMENT  = 6'd5;
   localparam logic [5:0] K_KW0      = 6'd6;
   localparam logic [5:0] K_CHAR     = 6'd19;
   localparam logic [5:0] K_LPAREN   = 6'd20;
   localparam logic [5:0] K_RPAREN   = 6'd21;
   localparam logic [5:0] K_LBRACE   = 6'd22;
   localparam logic [5:0] K_RBRACE   = 6'd23;
   localparam logic [5:0] K_LBRACKET = 6'd24;
   localparam logic [5:0] K_RBRACKET = 6'd25;
   localparam logic [5:0] K_COMMA    = 6'd26;
   localparam logic [5:0] K_DOT      = 6'd27;
   localparam logic [5:0] K_COLON    = 6'd28;
   localparam logic [5:0] K_SEMI     = 6'd29;
   localparam logic [5:0] K_ASSIGN   = 6'd30;
   localparam logic [5:0] K_PLUS_EQ  = 6'd31;
   localparam logic [5:0] K_MINUS_EQ = 6'd32;
   localparam logic [5:0] K_STAR_EQ  = 6'd33;
   localparam logic [5:0] K_SLASH_EQ = 6'd34;
   localparam logic [5:0] K_PLUS     = 6'd35;
   localparam logic [5:0] K_MINUS    = 6'd36;
   localparam logic [5:0] K_STAR     = 6'd37;
   localparam logic [5:0] K_SLASH    = 6'd38;
   localparam logic [5:0] K_EQ_EQ    = 6'd39;
   localparam logic [5:0] K_NOT_EQ   = 6'd40;
   localparam logic [5:0] K_LESS     = 6'd41;
   localparam logic [5:0] K_GREATER  = 6'd42;
   localparam logic [5:0] K_LESS_EQ  = 6'd43;
   localparam logic [5:0] K_GREAT_EQ = 6'd44;
   localparam logic [5:0] K_ARROW    = 6'd45;
   localparam logic [5:0] K_BANG     = 6'd46;

   // error codes
   localparam logic [2:0] E_NONE       = 3'd0;
   localparam logic [2:0] E_UNEXPECTED = 3'd1;
   localparam logic [2:0] E_EMPTY_CHAR = 3'd2;
   localparam logic [2:0] E_OPEN_CHAR  = 3'd3;
   localparam logic [2:0] E_OPEN_STR   = 3'd4;

   // keyword spellings, packed big-endian, with their lengths
   localparam logic [47:0] KW_WORD [KW_COUNT] = '{
      48'h0061_7263_6865, 48'h0000_7072_6f63, 48'h0000_0073_7973,
      48'h0000_6675_6e63, 48'h0000_006c_6574, 48'h0000_0066_6f72,
      48'h0000_0000_6966, 48'h0000_0000_696e, 48'h0000_6672_6565,
      48'h0062_7265_616b, 48'h6578_7465_726e, 48'h0000_006f_7574,
      48'h7265_7475_726e
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd6, 3'd3, 3'd6
   };

   typedef struct packed {
      logic       action;
      logic [7:0] byte_req;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [2:0]  error_code;
      logic [31:0] start_offset;
      logic [31:0] token_length;
      logic [19:0] start_line;
      logic [15:0] start_column;
      logic [7:0]  value;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [31:0] off;
      logic [31:0] len;
      logic [19:0] line;
      logic [15:0] col;
      logic [7:0]  val;
   } tok_type;

   // up to three tokens caused by one transaction
   typedef struct packed {
      logic [1:0]        cnt;
      tok_type [2:0]     toks;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type data;
   } qout_type;

endpackage

FILE: sv/stu_front.sv
module stu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  stu_pkg::req_type   req_data,
   output logic               push,
   output stu_pkg::bundle_type bundle
);

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_LCOM, M_BCOM, M_IDENT, M_NUM, M_NUMDOT, M_NUMFRAC,
      M_CHOPEN, M_CHESC, M_CHCLOSE, M_STR, M_STRESC, M_OP
   } mode_type;

   mode_type                         mode_ff, mode_in;
   logic [stu_pkg::OFFSET_BITS-1:0]  offs_ff, offs_in, toff_ff, toff_in;
   logic [stu_pkg::LINE_BITS-1:0]    line_ff, line_in, tline_ff, tline_in;
   logic [stu_pkg::COLUMN_BITS-1:0]  col_ff, col_in, tcol_ff, tcol_in;
   logic [stu_pkg::LEN_BITS-1:0]     tlen_ff, tlen_in;
   logic [47:0]                      wp_ff, wp_in;
   logic [7:0]                       cv_ff, cv_in;
   logic                             sf_ff, sf_in, ps_ff, ps_in;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] esc_value(input logic [7:0] c);
      logic [7:0] r;
      priority case (c)
         "n": r = 8'h0a;
         "t": r = 8'h09;
         "r": r = 8'h0d;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [stu_pkg::LEN_BITS-1:0] len_inc(
         input logic [stu_pkg::LEN_BITS-1:0] l);
      return (l == stu_pkg::LEN_MAX) ? l : l + stu_pkg::LEN_BITS'(1);
   endfunction

   function automatic logic [5:0] word_kind(input logic [47:0] wp,
                                           input logic [stu_pkg::LEN_BITS-1:0] l);
      logic [5:0] k;
      k = stu_pkg::K_IDENT;
      for (int i = 0; i < stu_pkg::KW_COUNT; i++) begin
         if (l == stu_pkg::LEN_BITS'(stu_pkg::KW_LEN[i]) && wp == stu_pkg::KW_WORD[i])
            k = stu_pkg::K_KW0 + 6'(i);
      end
      return k;
   endfunction

   function automatic logic [5:0] op_single(input logic [7:0] op);
      logic [5:0] k;
      priority case (op)
         "+": k = stu_pkg::K_PLUS;
         "-": k = stu_pkg::K_MINUS;
         "*": k = stu_pkg::K_STAR;
         "=": k = stu_pkg::K_ASSIGN;
         "!": k = stu_pkg::K_BANG;
         "<": k = stu_pkg::K_LESS;
         default: k = stu_pkg::K_GREATER;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] op_with_eq(input logic [7:0] op);
      logic [5:0] k;
      priority case (op)
         "+": k = stu_pkg::K_PLUS_EQ;
         "-": k = stu_pkg::K_MINUS_EQ;
         "*": k = stu_pkg::K_STAR_EQ;
         "=": k = stu_pkg::K_EQ_EQ;
         "!": k = stu_pkg::K_NOT_EQ;
         "<": k = stu_pkg::K_LESS_EQ;
         default: k = stu_pkg::K_GREAT_EQ;
      endcase
      return k;
   endfunction

   // next lexer state and the tokens of this transaction
   always_comb begin
      logic [7:0]  c;
      logic [1:0]  n;
      logic        redo;
      logic [64:0] dsum;
      logic [32:0] csum;
      logic [stu_pkg::OFFSET_BITS-1:0] doff;
      logic [stu_pkg::COLUMN_BITS-1:0] dcol;
      logic [5:0]  pk;
      logic [1:0]  dig;
      logic [2:0]  pe;
      logic        pemit;
      logic        dot;
      c = req_data.byte_req;
      n = 2'd0;
      redo = 1'b0;
      pemit = 1'b0;
      pk = stu_pkg::K_EOF;
      pe = stu_pkg::E_NONE;
      dot = 1'b0;
      dig = 2'd0;
      mode_in = mode_ff;
      offs_in = offs_ff;
      line_in = line_ff;
      col_in = col_ff;
      toff_in = toff_ff;
      tline_in = tline_ff;
      tcol_in = tcol_ff;
      tlen_in = tlen_ff;
      wp_in = wp_ff;
      cv_in = cv_ff;
      sf_in = sf_ff;
      ps_in = ps_ff;
      bundle = '0;

      // position of a dot that trails a number
      dsum = 65'(toff_ff) + 65'(tlen_ff);
      doff = (dsum > 65'(stu_pkg::OFF_MAX)) ? stu_pkg::OFF_MAX
                                             : stu_pkg::OFFSET_BITS'(dsum);
      csum = 33'(tcol_ff) + 33'(tlen_ff);
      dcol = (csum > 33'(stu_pkg::COL_MAX)) ? stu_pkg::COL_MAX
                                             : stu_pkg::COLUMN_BITS'(csum);

      if (req_data.action) begin
         // flush the open token, then end of source
         pemit = 1'b1;
         unique case (mode_ff)
            M_SLASH: pk = stu_pkg::K_SLASH;
            M_LCOM, M_BCOM: pk = stu_pkg::K_COMMENT;
            M_IDENT: pk = word_kind(wp_ff, tlen_ff);
            M_NUM, M_NUMFRAC: pk = stu_pkg::K_NUMBER;
            M_NUMDOT: begin
               pk = stu_pkg::K_NUMBER;
               dot = 1'b1;
            end
            M_CHOPEN: begin
               pk = stu_pkg::K_ERR;
               pe = stu_pkg::E_EMPTY_CHAR;
            end
            M_CHESC, M_CHCLOSE: begin
               pk = stu_pkg::K_ERR;
               pe = stu_pkg::E_OPEN_CHAR;
            end
            M_STR, M_STRESC: begin
               pk = stu_pkg::K_ERR;
               pe = stu_pkg::E_OPEN_STR;
            end
            M_OP: pk = op_single(cv_ff);
            default: pemit = 1'b0;
         endcase
         if (pemit) begin
            bundle.toks[n] = '{pk, pe, 32'(toff_ff), tlen_ff, 20'(tline_ff),
                               16'(tcol_ff), 8'd0};
            n = n + 2'd1;
         end
         if (dot) begin
            bundle.toks[n] = '{stu_pkg::K_DOT, stu_pkg::E_NONE, 32'(doff), 32'd1,
                               20'(tline_ff), 16'(dcol), 8'd0};
            n = n + 2'd1;
         end
         mode_in = M_IDLE;
         ps_in = 1'b0;
         bundle.toks[n] = '{stu_pkg::K_EOF, stu_pkg::E_NONE, 32'(offs_ff), 32'd0,
                            20'(line_ff), 16'(col_ff), 8'd0};
         n = n + 2'd1;
      end else begin
         // first pass in the current mode
         unique case (mode_ff)
            M_IDLE: redo = 1'b1;
            M_SLASH: begin
               if (c == "*") begin
                  tlen_in = len_inc(tlen_ff);
                  ps_in = 1'b0;
                  mode_in = M_BCOM;
               end else if (c == "/") begin
                  tlen_in = len_inc(tlen_ff);
                  mode_in = M_LCOM;
               end else if (c == "=") begin
                  tlen_in = len_inc(tlen_ff);
                  pemit = 1'b1;
                  pk = stu_pkg::K_SLASH_EQ;
                  mode_in = M_IDLE;
               end else begin
                  pemit = 1'b1;
                  pk = stu_pkg::K_SLASH;
                  mode_in = M_IDLE;
                  redo = 1'b1;
               end
            end
            M_LCOM: begin
               if (c == 8'h0a) begin
                  pemit = 1'b1;
                  pk = stu_pkg::K_COMMENT;
                  mode_in = M_IDLE;
                  redo = 1'b1;
               end else begin
                  tlen_in = len_inc(tlen_ff);
               end
            end
            M_BCOM: begin
               tlen_in = len_inc(tlen_ff);
               if (ps_ff && c == "/") begin
                  pemit = 1'b1;
                  pk = stu_pkg::K_COMMENT;
                  ps_in = 1'b0;
                  mode_in = M_IDLE;
               end else begin
                  ps_in = (c == "*");
               end
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  tlen_in = len_inc(tlen_ff);
                  if (tlen_in <= stu_pkg::LEN_BITS'(6))
                     wp_in = {wp_ff[39:0], c};
               end else begin
                  pemit = 1'b1;
                  pk = word_kind(wp_ff, tlen_ff);
                  mode_in = M_IDLE;
                  redo = 1'b1;
               end
            end
            M_NUM, M_NUMFRAC: begin
               if (is_digit(c)) begin
                  tlen_in = len_inc(tlen_ff);
               end else if (c == "." && mode_ff == M_NUM) begin
                  mode_in = M_NUMDOT;
               end else begin
                  pemit = 1'b1;
                  pk = stu_pkg::K_NUMBER;
                  mode_in = M_IDLE;
                  redo = 1'b1;
               end
            end
            M_NUMDOT: begin
               if (is_digit(c)) begin
                  tlen_in = len_inc(len_inc(tlen_ff));
                  mode_in = M_NUMFRAC;
               end else begin
                  pemit = 1'b1;
                  pk = stu_pkg::K_NUMBER;
                  dot = 1'b1;
                  mode_in = M_IDLE;
                  redo = 1'b1;
               end
            end
            M_CHOPEN: begin
               if (c == "\\") begin
                  tlen_in = len_inc(tlen_ff);
                  mode_in = M_CHESC;
               end else if (c == "'") begin
                  pemit = 1'b1;
                  pk = stu_pkg::K_ERR;
                  pe = stu_pkg::E_EMPTY_CHAR;
                  mode_in = M_IDLE;
                  redo = 1'b1;
               end else begin
                  cv_in = c;
                  tlen_in = len_inc(tlen_ff);
                  mode_in = M_CHCLOSE;
               end
            end
            M_CHESC: begin
               cv_in = esc_value(c);
               tlen_in = len_inc(tlen_ff);
               mode_in = M_CHCLOSE;
            end
            M_CHCLOSE: begin
               mode_in = M_IDLE;
               pemit = 1'b1;
               if (c == "'") begin
                  tlen_in = len_inc(tlen_ff);
                  pk = stu_pkg::K_CHAR;
               end else begin
                  pk = stu_pkg::K_ERR;
                  pe = stu_pkg::E_OPEN_CHAR;
                  redo = 1'b1;
               end
            end
            M_OP: begin
               mode_in = M_IDLE;
               pemit = 1'b1;
               if (cv_ff == "-" && c == ">") begin
                  tlen_in = len_inc(tlen_ff);
                  pk = stu_pkg::K_ARROW;
               end else if (c == "=") begin
                  tlen_in = len_inc(tlen_ff);
                  pk = op_with_eq(cv_ff);
               end else begin
                  pk = op_single(cv_ff);
                  redo = 1'b1;
               end
            end
            M_STR, M_STRESC: begin
               tlen_in = len_inc(tlen_ff);
               if (mode_ff == M_STR && c == "\"") begin
                  bundle.toks[n] = '{stu_pkg::K_RBRACE, stu_pkg::E_NONE, 32'(toff_ff),
                                     32'd1, 20'(tline_ff), 16'(tcol_ff), 8'd0};
                  n = n + 2'd1;
                  mode_in = M_IDLE;
               end else if (mode_ff == M_STR && c == "\\") begin
                  mode_in = M_STRESC;
               end else begin
                  // one string byte expands to an optional comma and a number
                  if (mode_ff == M_STRESC)
                     cv_in = esc_value(c);
                  else
                     cv_in = c;
                  dig = (cv_in < 8'd10) ? 2'd1 : ((cv_in < 8'd100) ? 2'd2 : 2'd3);
                  if (!sf_ff) begin
                     bundle.toks[n] = '{stu_pkg::K_COMMA, stu_pkg::E_NONE, 32'(toff_ff),
                                        32'd1, 20'(tline_ff), 16'(tcol_ff), 8'd0};
                     n = n + 2'd1;
                  end
                  bundle.toks[n] = '{stu_pkg::K_NUMBER, stu_pkg::E_NONE, 32'(toff_ff),
                                     32'(dig), 20'(tline_ff), 16'(tcol_ff), cv_in};
                  n = n + 2'd1;
                  sf_in = 1'b0;
                  cv_in = cv_ff;
                  mode_in = M_STR;
               end
            end
            default: begin
               mode_in = M_IDLE;
               redo = 1'b1;
            end
         endcase

         if (pemit) begin
            bundle.toks[n] = '{pk, pe, 32'(toff_ff), tlen_in, 20'(tline_ff),
                               16'(tcol_ff), (pk == stu_pkg::K_CHAR) ? cv_ff : 8'd0};
            n = n + 2'd1;
         end
         if (dot) begin
            bundle.toks[n] = '{stu_pkg::K_DOT, stu_pkg::E_NONE, 32'(doff), 32'd1,
                               20'(tline_ff), 16'(dcol), 8'd0};
            n = n + 2'd1;
         end

         // second pass: the byte starts something new
         if (redo && !(c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a)) begin
            toff_in = offs_ff;
            tline_in = line_ff;
            tcol_in = col_ff;
            tlen_in = stu_pkg::LEN_BITS'(1);
            pemit = 1'b1;
            pe = stu_pkg::E_NONE;
            pk = stu_pkg::K_ERR;
            if (c == "/") begin
               mode_in = M_SLASH;
               pemit = 1'b0;
            end else if (is_alpha(c)) begin
               wp_in = 48'(c);
               mode_in = M_IDENT;
               pemit = 1'b0;
            end else if (is_digit(c)) begin
               mode_in = M_NUM;
               pemit = 1'b0;
            end else if (c == "\"") begin
               pk = stu_pkg::K_LBRACE;
               sf_in = 1'b1;
               mode_in = M_STR;
            end else if (c == "'") begin
               cv_in = 8'd0;
               mode_in = M_CHOPEN;
               pemit = 1'b0;
            end else begin
               priority case (c)
                  "(": pk = stu_pkg::K_LPAREN;
                  ")": pk = stu_pkg::K_RPAREN;
                  "{": pk = stu_pkg::K_LBRACE;
                  "}": pk = stu_pkg::K_RBRACE;
                  "[": pk = stu_pkg::K_LBRACKET;
                  "]": pk = stu_pkg::K_RBRACKET;
                  ",": pk = stu_pkg::K_COMMA;
                  ".": pk = stu_pkg::K_DOT;
                  ":": pk = stu_pkg::K_COLON;
                  ";": pk = stu_pkg::K_SEMI;
                  "+", "-", "*", "=", "!", "<", ">": begin
                     cv_in = c;
                     mode_in = M_OP;
                     pemit = 1'b0;
                  end
                  default: pe = stu_pkg::E_UNEXPECTED;
               endcase
            end
            if (pemit) begin
               bundle.toks[n] = '{pk, pe, 32'(offs_ff), 32'd1, 20'(line_ff),
                                  16'(col_ff), 8'd0};
               n = n + 2'd1;
            end
         end

         // advance the source position
         if (offs_ff != stu_pkg::OFF_MAX)
            offs_in = offs_ff + stu_pkg::OFFSET_BITS'(1);
         if (c == 8'h0a) begin
            if (line_ff != stu_pkg::LINE_MAX)
               line_in = line_ff + stu_pkg::LINE_BITS'(1);
            col_in = stu_pkg::COLUMN_BITS'(1);
         end else if (col_ff != stu_pkg::COL_MAX) begin
            col_in = col_ff + stu_pkg::COLUMN_BITS'(1);
         end
      end
      bundle.cnt = n;
   end

   assign push = accept && (bundle.cnt != 2'd0);

   // hold lexer state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         offs_ff <= '0;
         line_ff <= stu_pkg::LINE_BITS'(1);
         col_ff <= stu_pkg::COLUMN_BITS'(1);
         toff_ff <= '0;
         tline_ff <= stu_pkg::LINE_BITS'(1);
         tcol_ff <= stu_pkg::COLUMN_BITS'(1);
         tlen_ff <= '0;
         wp_ff <= '0;
         cv_ff <= '0;
         sf_ff <= 1'b1;
         ps_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         offs_ff <= offs_in;
         line_ff <= line_in;
         col_ff <= col_in;
         toff_ff <= toff_in;
         tline_ff <= tline_in;
         tcol_ff <= tcol_in;
         tlen_ff <= tlen_in;
         wp_ff <= wp_in;
         cv_ff <= cv_in;
         sf_ff <= sf_in;
         ps_ff <= ps_in;
      end
   end

endmodule

FILE: sv/stu_queue.sv
module stu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stu_pkg::bundle_type push_data,
   input  logic                pop,
   output stu_pkg::qout_type   head,
   output logic                full
);

   stu_pkg::bundle_type             q_mem [stu_pkg::QUEUE_DEPTH];
   logic [stu_pkg::QPTR_BITS-1:0]   wr_ff, rd_ff;
   logic [stu_pkg::QPTR_BITS:0]     cnt_ff;

   assign full = (cnt_ff == (stu_pkg::QPTR_BITS+1)'(stu_pkg::QUEUE_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.data = q_mem[rd_ff];

   // store bundles
   always_ff @(posedge clock) begin
      if (push)
         q_mem[wr_ff] <= push_data;
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)
            wr_ff <= wr_ff + stu_pkg::QPTR_BITS'(1);
         if (pop)
            rd_ff <= rd_ff + stu_pkg::QPTR_BITS'(1);
         if (push && !pop)
            cnt_ff <= cnt_ff + (stu_pkg::QPTR_BITS+1)'(1);
         else if (pop && !push)
            cnt_ff <= cnt_ff - (stu_pkg::QPTR_BITS+1)'(1);
      end
   end

endmodule

FILE: sv/stu_back.sv
module stu_back (
   input  logic               clock,
   input  logic               reset,
   input  stu_pkg::qout_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stu_pkg::rsp_type   rsp_data
);

   stu_pkg::bundle_type cur_ff;
   logic                cur_valid_ff;
   logic [1:0]          idx_ff;
   logic                out_valid_ff;
   stu_pkg::rsp_type    out_ff;
   logic                can_load, is_last;
   stu_pkg::tok_type    tk;

   assign can_load = !out_valid_ff || !rsp_stall;
   assign is_last = (idx_ff == cur_ff.cnt - 2'd1);
   assign pop = head.valid && (!cur_valid_ff || (can_load && is_last));
   assign tk = cur_ff.toks[idx_ff];
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // load the output register one token at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (can_load && cur_valid_ff) begin
            out_valid_ff <= 1'b1;
            idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
            if (is_last)
               cur_valid_ff <= 1'b0;
         end else if (can_load) begin
            out_valid_ff <= 1'b0;
         end
         if (pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff <= 2'd0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop)
         cur_ff <= head.data;
      if (can_load && cur_valid_ff)
         out_ff <= '{tk.kind, tk.err, tk.off, tk.len, tk.line, tk.col, tk.val, is_last};
   end

endmodule

FILE: sv/source_tokenizer_unit.sv
// Byte-serial source tokenizer.
// Input channel req_: one transaction per source byte (action 0) or end of
// source (action 1, which flushes the open token and adds an EOF token).
// Result channel rsp_: one token per transaction; last_of_run marks the final
// token caused by one input transaction. A byte causes zero to three tokens.
// Throughput: one input byte per cycle while the token queue has room; the
// output side drains one token per cycle while rsp_stall is low. The lexer
// state machine in the front decides all tokens of a byte in the cycle it is
// accepted; a four-entry queue of token bundles decouples it from the output
// serializer. The tokens of a byte pass through the queue, the current-bundle
// register and the output register before they appear on rsp_.
// Reset (synchronous) returns the lexer to idle at offset 0, line 1, column 1
// and empties the queue and output register.
// When rsp_stall is high the output holds; the queue fills and then req_stall
// rises until room frees up.
module source_tokenizer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stu_pkg::rsp_type  rsp_data
);

   logic                accept, push, pop, full;
   stu_pkg::bundle_type bundle;
   stu_pkg::qout_type   head;

   assign req_stall = full;
   assign accept = req_valid && !full;

   stu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .bundle   (bundle)
   );

   stu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .full      (full)
   );

   stu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/stu_checker.sv
module stu_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stu_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == stu_pkg::K_EOF |-> rsp_data.last_of_run)
      else $error("EOF not last of run");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.token_kind == stu_pkg::K_ERR) ==
                     (rsp_data.error_code != stu_pkg::E_NONE)))
      else $error("error code does not match kind");

   a_value_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.value != 8'd0 |->
         rsp_data.token_kind == stu_pkg::K_CHAR || rsp_data.token_kind == stu_pkg::K_NUMBER)
      else $error("value on a token that carries none");

endmodule

bind source_tokenizer_unit stu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: dv/tb.sv
module tb;

   typedef enum int {
      LX_IDLE, LX_SLASH, LX_LCOM, LX_BCOM, LX_IDENT, LX_NUM, LX_NUMDOT, LX_NUMFRAC,
      LX_CHOPEN, LX_CHESC, LX_CHCLOSE, LX_STR, LX_STRESC, LX_OP
   } lex_mode_type;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // one row of the directed table; a checked row fixes the first token's kind and error
   typedef struct {
      logic       act;
      logic [7:0] ch;
      bit         chk;
      logic [5:0] kind;
      logic [2:0] err;
   } row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   stu_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   stu_pkg::rsp_type rsp_data;

   source_tokenizer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // lexer shadow state
   lex_mode_type      mode;
   logic [31:0]       cur_off, ts_off, tlen;
   logic [19:0]       cur_line, ts_line;
   logic [15:0]       cur_col, ts_col;
   logic [47:0]       wpre;
   logic [7:0]        cval;
   bit                sfirst, pstar;

   stu_pkg::rsp_type token_q[$];
   stu_pkg::rsp_type run_buf[$];
   int      mismatches;
   bit      quiet;
   bit      long_hold_req;
   bit      hold_done;
   logic [7:0] byte_q[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function void emit_at(logic [5:0] k, logic [2:0] e, logic [31:0] o, logic [31:0] l,
                         logic [19:0] ln, logic [15:0] cl, logic [7:0] v);
      stu_pkg::rsp_type t;
      t = '{token_kind: k, error_code: e, start_offset: o, token_length: l,
            start_line: ln, start_column: cl, value: v, last_of_run: 1'b0};
      if (run_buf.size() < 3) run_buf.push_back(t);
   endfunction

   function void emit_tok(logic [5:0] k, logic [2:0] e, logic [7:0] v);
      emit_at(k, e, ts_off, tlen, ts_line, ts_col, v);
   endfunction

   function void emit_piece(logic [5:0] k, logic [31:0] l, logic [7:0] v);
      emit_at(k, stu_pkg::E_NONE, ts_off, l, ts_line, ts_col, v);
   endfunction

   function void grow();
      if (tlen != stu_pkg::LEN_MAX) tlen = tlen + 1;
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function logic [7:0] unescape(logic [7:0] c);
      if (c == "n") return 8'h0a;
      if (c == "t") return 8'h09;
      if (c == "r") return 8'h0d;
      return c;
   endfunction

   function logic [5:0] word_kind();
      if (tlen > 6) return stu_pkg::K_IDENT;
      for (int i = 0; i < stu_pkg::KW_COUNT; i++)
         if (stu_pkg::KW_LEN[i] == tlen && stu_pkg::KW_WORD[i] == wpre)
            return stu_pkg::K_KW0 + 6'(i);
      return stu_pkg::K_IDENT;
   endfunction

   function logic [5:0] op_alone(logic [7:0] op);
      case (op)
         "+": return stu_pkg::K_PLUS;
         "-": return stu_pkg::K_MINUS;
         "*": return stu_pkg::K_STAR;
         "=": return stu_pkg::K_ASSIGN;
         "!": return stu_pkg::K_BANG;
         "<": return stu_pkg::K_LESS;
         default: return stu_pkg::K_GREATER;
      endcase
   endfunction

   function logic [5:0] op_eq(logic [7:0] op);
      case (op)
         "+": return stu_pkg::K_PLUS_EQ;
         "-": return stu_pkg::K_MINUS_EQ;
         "*": return stu_pkg::K_STAR_EQ;
         "=": return stu_pkg::K_EQ_EQ;
         "!": return stu_pkg::K_NOT_EQ;
         "<": return stu_pkg::K_LESS_EQ;
         default: return stu_pkg::K_GREAT_EQ;
      endcase
   endfunction

   // the dot sits right after the integer part
   function void emit_trailing_dot();
      logic [32:0] o, cl;
      o  = {1'b0, ts_off} + tlen;
      cl = {17'b0, ts_col} + tlen;
      if (o > stu_pkg::OFF_MAX) o = stu_pkg::OFF_MAX;
      if (cl > stu_pkg::COL_MAX) cl = stu_pkg::COL_MAX;
      emit_at(stu_pkg::K_DOT, stu_pkg::E_NONE, o[31:0], 1, ts_line, cl[15:0], 0);
   endfunction

   function void string_char(logic [7:0] v);
      if (!sfirst) emit_piece(stu_pkg::K_COMMA, 1, 0);
      emit_piece(stu_pkg::K_NUMBER, v < 10 ? 1 : (v < 100 ? 2 : 3), v);
      sfirst = 0;
   endfunction

   function void open_token();
      ts_off = cur_off;
      ts_line = cur_line;
      ts_col = cur_col;
      tlen = 1;
   endfunction

   function void idle_char(logic [7:0] c);
      if (c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a) return;
      open_token();
      if (c == "/") begin mode = LX_SLASH; return; end
      if (is_alpha(c)) begin wpre = c; mode = LX_IDENT; return; end
      if (is_digit(c)) begin mode = LX_NUM; return; end
      if (c == 8'h22) begin
         emit_piece(stu_pkg::K_LBRACE, 1, 0);
         sfirst = 1;
         mode = LX_STR;
         return;
      end
      if (c == 8'h27) begin cval = 0; mode = LX_CHOPEN; return; end
      case (c)
         "(": emit_tok(stu_pkg::K_LPAREN, stu_pkg::E_NONE, 0);
         ")": emit_tok(stu_pkg::K_RPAREN, stu_pkg::E_NONE, 0);
         "{": emit_tok(stu_pkg::K_LBRACE, stu_pkg::E_NONE, 0);
         "}": emit_tok(stu_pkg::K_RBRACE, stu_pkg::E_NONE, 0);
         "[": emit_tok(stu_pkg::K_LBRACKET, stu_pkg::E_NONE, 0);
         "]": emit_tok(stu_pkg::K_RBRACKET, stu_pkg::E_NONE, 0);
         ",": emit_tok(stu_pkg::K_COMMA, stu_pkg::E_NONE, 0);
         ".": emit_tok(stu_pkg::K_DOT, stu_pkg::E_NONE, 0);
         ":": emit_tok(stu_pkg::K_COLON, stu_pkg::E_NONE, 0);
         ";": emit_tok(stu_pkg::K_SEMI, stu_pkg::E_NONE, 0);
         "+", "-", "*", "=", "!", "<", ">": begin
            cval = c;
            mode = LX_OP;
         end
         default: emit_tok(stu_pkg::K_ERR, stu_pkg::E_UNEXPECTED, 0);
      endcase
   endfunction

   // return 1 when the byte is consumed, 0 when it must be lexed again
   function bit lex_char(logic [7:0] c);
      case (mode)
         LX_IDLE: begin idle_char(c); return 1; end
         LX_SLASH: begin
            if (c == "*") begin grow(); pstar = 0; mode = LX_BCOM; return 1; end
            if (c == "/") begin grow(); mode = LX_LCOM; return 1; end
            mode = LX_IDLE;
            if (c == "=") begin
               grow();
               emit_tok(stu_pkg::K_SLASH_EQ, stu_pkg::E_NONE, 0);
               return 1;
            end
            emit_tok(stu_pkg::K_SLASH, stu_pkg::E_NONE, 0);
            return 0;
         end
         LX_LCOM: begin
            if (c == 8'h0a) begin
               emit_tok(stu_pkg::K_COMMENT, stu_pkg::E_NONE, 0);
               mode = LX_IDLE;
               return 0;
            end
            grow();
            return 1;
         end
         LX_BCOM: begin
            grow();
            if (pstar && c == "/") begin
               emit_tok(stu_pkg::K_COMMENT, stu_pkg::E_NONE, 0);
               pstar = 0;
               mode = LX_IDLE;
               return 1;
            end
            pstar = (c == "*");
            return 1;
         end
         LX_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               grow();
               if (tlen <= 6) wpre = {wpre[39:0], c};
               return 1;
            end
            emit_tok(word_kind(), stu_pkg::E_NONE, 0);
            mode = LX_IDLE;
            return 0;
         end
         LX_NUM: begin
            if (is_digit(c)) begin grow(); return 1; end
            if (c == ".") begin mode = LX_NUMDOT; return 1; end
            emit_tok(stu_pkg::K_NUMBER, stu_pkg::E_NONE, 0);
            mode = LX_IDLE;
            return 0;
         end
         LX_NUMDOT: begin
            mode = LX_IDLE;
            if (is_digit(c)) begin grow(); grow(); mode = LX_NUMFRAC; return 1; end
            emit_tok(stu_pkg::K_NUMBER, stu_pkg::E_NONE, 0);
            emit_trailing_dot();
            return 0;
         end
         LX_NUMFRAC: begin
            if (is_digit(c)) begin grow(); return 1; end
            emit_tok(stu_pkg::K_NUMBER, stu_pkg::E_NONE, 0);
            mode = LX_IDLE;
            return 0;
         end
         LX_CHOPEN: begin
            if (c == 8'h5c) begin grow(); mode = LX_CHESC; return 1; end
            if (c == 8'h27) begin
               emit_tok(stu_pkg::K_ERR, stu_pkg::E_EMPTY_CHAR, 0);
               mode = LX_IDLE;
               return 0;
            end
            cval = c;
            grow();
            mode = LX_CHCLOSE;
            return 1;
         end
         LX_CHESC: begin
            cval = unescape(c);
            grow();
            mode = LX_CHCLOSE;
            return 1;
         end
         LX_CHCLOSE: begin
            mode = LX_IDLE;
            if (c == 8'h27) begin
               grow();
               emit_tok(stu_pkg::K_CHAR, stu_pkg::E_NONE, cval);
               return 1;
            end
            emit_tok(stu_pkg::K_ERR, stu_pkg::E_OPEN_CHAR, 0);
            return 0;
         end
         LX_STR: begin
            grow();
            if (c == 8'h22) begin
               emit_piece(stu_pkg::K_RBRACE, 1, 0);
               mode = LX_IDLE;
               return 1;
            end
            if (c == 8'h5c) begin mode = LX_STRESC; return 1; end
            string_char(c);
            return 1;
         end
         LX_STRESC: begin
            grow();
            string_char(unescape(c));
            mode = LX_STR;
            return 1;
         end
         default: begin
            mode = LX_IDLE;
            if (cval == "-" && c == ">") begin
               grow();
               emit_tok(stu_pkg::K_ARROW, stu_pkg::E_NONE, 0);
               return 1;
            end
            if (c == "=") begin
               grow();
               emit_tok(op_eq(cval), stu_pkg::E_NONE, 0);
               return 1;
            end
            emit_tok(op_alone(cval), stu_pkg::E_NONE, 0);
            return 0;
         end
      endcase
   endfunction

   function void flush_source();
      case (mode)
         LX_SLASH: emit_tok(stu_pkg::K_SLASH, stu_pkg::E_NONE, 0);
         LX_LCOM, LX_BCOM: emit_tok(stu_pkg::K_COMMENT, stu_pkg::E_NONE, 0);
         LX_IDENT: emit_tok(word_kind(), stu_pkg::E_NONE, 0);
         LX_NUM, LX_NUMFRAC: emit_tok(stu_pkg::K_NUMBER, stu_pkg::E_NONE, 0);
         LX_NUMDOT: begin
            emit_tok(stu_pkg::K_NUMBER, stu_pkg::E_NONE, 0);
            emit_trailing_dot();
         end
         LX_CHOPEN: emit_tok(stu_pkg::K_ERR, stu_pkg::E_EMPTY_CHAR, 0);
         LX_CHESC, LX_CHCLOSE: emit_tok(stu_pkg::K_ERR, stu_pkg::E_OPEN_CHAR, 0);
         LX_STR, LX_STRESC: emit_tok(stu_pkg::K_ERR, stu_pkg::E_OPEN_STR, 0);
         LX_OP: emit_tok(op_alone(cval), stu_pkg::E_NONE, 0);
         default: ;
      endcase
      mode = LX_IDLE;
      pstar = 0;
      emit_at(stu_pkg::K_EOF, stu_pkg::E_NONE, cur_off, 0, cur_line, cur_col, 0);
   endfunction

   // work out the tokens one accepted transaction causes, into run_buf
   function void predict_tokens(stu_pkg::req_type r);
      run_buf.delete();
      if (r.action == ACT_END) begin
         flush_source();
      end else begin
         for (int g = 0; g < 4; g++)
            if (lex_char(r.byte_req)) break;
         if (cur_off != stu_pkg::OFF_MAX) cur_off = cur_off + 1;
         if (r.byte_req == 8'h0a) begin
            if (cur_line != stu_pkg::LINE_MAX) cur_line = cur_line + 1;
            cur_col = 1;
         end else if (cur_col != stu_pkg::COL_MAX) begin
            cur_col = cur_col + 1;
         end
      end
      if (run_buf.size() > 0) run_buf[run_buf.size()-1].last_of_run = 1'b1;
   endfunction

   // offer one transaction, hold it until taken, then queue its tokens
   task send(logic act, logic [7:0] ch, bit chk, logic [5:0] kind, logic [2:0] err);
      stu_pkg::req_type r;
      r.action = act;
      r.byte_req = ch;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_tokens(r);
      if (chk && run_buf.size() > 0) begin
         run_buf[0].token_kind = kind;
         run_buf[0].error_code = err;
      end
      foreach (run_buf[i]) token_q.push_back(run_buf[i]);
      @(negedge clock);
   endtask

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endfunction

   // build one random snippet of source text into byte_q
   function automatic void make_snippet();
      string kws[$] = '{"proc", "sys", "func", "let", "for", "if", "in", "free",
                        "break", "extern", "out", "return", "forx", "i"};
      string ops = "+-*=!<>";
      string punct = "(){}[],.:;";
      int n;
      case ($urandom_range(0, 12))
         0: push_text(kws[$urandom_range(0, kws.size()-1)]);
         1: begin
            n = $urandom_range(1, 9);
            byte_q.push_back("a" + $urandom_range(0, 25));
            for (int i = 1; i < n; i++)
               byte_q.push_back($urandom_range(0, 2) == 0 ? "0" + $urandom_range(0, 9)
                                : ($urandom_range(0, 1) ? "_" : "A" + $urandom_range(0, 25)));
         end
         2: begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) byte_q.push_back("0" + $urandom_range(0, 9));
            if ($urandom_range(0, 2) == 0) byte_q.push_back(".");
            if ($urandom_range(0, 1)) byte_q.push_back("0" + $urandom_range(0, 9));
         end
         3: begin
            byte_q.push_back(ops[$urandom_range(0, ops.len()-1)]);
            case ($urandom_range(0, 2))
               0: byte_q.push_back("=");
               1: byte_q.push_back(">");
               default: ;
            endcase
         end
         4: byte_q.push_back(punct[$urandom_range(0, punct.len()-1)]);
         5: begin
            byte_q.push_back(8'h22);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 4) == 0) byte_q.push_back(8'h5c);
               byte_q.push_back($urandom_range(0, 3) == 0 ? $urandom_range(1, 255)
                                : "a" + $urandom_range(0, 25));
            end
            if ($urandom_range(0, 7) != 0) byte_q.push_back(8'h22);
         end
         6: begin
            byte_q.push_back(8'h27);
            if ($urandom_range(0, 2) == 0) byte_q.push_back(8'h5c);
            if ($urandom_range(0, 5) != 0) byte_q.push_back($urandom_range(1, 255));
            if ($urandom_range(0, 5) != 0) byte_q.push_back(8'h27);
         end
         7: begin
            push_text($urandom_range(0, 1) ? "//x*" : "/*a*");
            if ($urandom_range(0, 1)) push_text("*/");
            byte_q.push_back(8'h0a);
         end
         8: byte_q.push_back($urandom_range(0, 1) ? 8'h0a : 8'h09);
         9: byte_q.push_back($urandom_range(0, 1) ? "/" : " ");
         10: byte_q.push_back($urandom_range(1, 255));
         default: byte_q.push_back(" ");
      endcase
      if ($urandom_range(0, 1)) byte_q.push_back(" ");
   endfunction

   // receiver back-pressure: short random bursts, one long hold on request
   initial begin
      int burst, hold;
      burst = 0;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            hold = 60;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each token taken from the block with the oldest expected one
   always @(posedge clock) begin
      stu_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %p", rsp_data);
         end else begin
            want = token_q.pop_front();
            if (want.token_kind !== rsp_data.token_kind
                || want.error_code !== rsp_data.error_code
                || want.start_offset !== rsp_data.start_offset
                || want.token_length !== rsp_data.token_length
                || want.start_line !== rsp_data.start_line
                || want.start_column !== rsp_data.start_column
                || want.value !== rsp_data.value
                || want.last_of_run !== rsp_data.last_of_run) begin
               mismatches++;
               if (mismatches <= 10) $display("token mismatch: expected %p actual %p",
                                              want, rsp_data);
            end
         end
      end
   end

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      row_type dir[$];
      int sent, wait_cnt;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      mismatches = 0;
      quiet = 0;
      long_hold_req = 0;
      hold_done = 0;
      mode = LX_IDLE;
      cur_off = 0; cur_line = 1; cur_col = 1;
      ts_off = 0; ts_line = 1; ts_col = 1; tlen = 0;
      wpre = 0; cval = 0; sfirst = 1; pstar = 0;

      // directed table: extremes, special cases and fixed results
      dir = '{
         '{ACT_BYTE, "(", 1, stu_pkg::K_LPAREN, stu_pkg::E_NONE},
         '{ACT_BYTE, 8'hff, 1, stu_pkg::K_ERR, stu_pkg::E_UNEXPECTED},
         '{ACT_BYTE, 8'h00, 1, stu_pkg::K_ERR, stu_pkg::E_UNEXPECTED},
         '{ACT_BYTE, 8'h27, 0, 0, 0},
         '{ACT_BYTE, 8'h27, 1, stu_pkg::K_ERR, stu_pkg::E_EMPTY_CHAR},
         '{ACT_BYTE, 8'h5c, 0, 0, 0},
         '{ACT_BYTE, "n", 0, 0, 0},
         '{ACT_BYTE, 8'h27, 1, stu_pkg::K_CHAR, stu_pkg::E_NONE},
         '{ACT_BYTE, "7", 0, 0, 0},
         '{ACT_BYTE, ".", 0, 0, 0},
         '{ACT_BYTE, "x", 0, 0, 0},
         '{ACT_BYTE, "-", 1, stu_pkg::K_IDENT, stu_pkg::E_NONE},
         '{ACT_BYTE, ">", 1, stu_pkg::K_ARROW, stu_pkg::E_NONE},
         '{ACT_BYTE, 8'h0a, 0, 0, 0},
         '{ACT_BYTE, 8'h22, 1, stu_pkg::K_LBRACE, stu_pkg::E_NONE},
         '{ACT_BYTE, 8'h80, 0, 0, 0},
         '{ACT_BYTE, 8'h5c, 0, 0, 0},
         '{ACT_BYTE, "t", 0, 0, 0},
         '{ACT_BYTE, 8'h22, 1, stu_pkg::K_RBRACE, stu_pkg::E_NONE},
         '{ACT_BYTE, "/", 0, 0, 0},
         '{ACT_BYTE, "*", 0, 0, 0},
         '{ACT_BYTE, "*", 0, 0, 0},
         '{ACT_BYTE, "/", 1, stu_pkg::K_COMMENT, stu_pkg::E_NONE},
         '{ACT_BYTE, 8'h22, 0, 0, 0},
         '{ACT_END, 8'h7f, 1, stu_pkg::K_ERR, stu_pkg::E_OPEN_STR}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir[i]) send(dir[i].act, dir[i].ch, dir[i].chk, dir[i].kind, dir[i].err);

      // random source text, mostly well formed, with one long output hold
      sent = 0;
      while (sent < 255) begin
         if (sent >= 100 && !hold_done) begin
            long_hold_req = 1;
            hold_done = 1;
         end
         if (sent > 215) quiet = 1;
         if ($urandom_range(0, 30) == 0) begin
            send(ACT_END, $urandom_range(0, 255), 0, 0, 0);
            sent++;
         end else begin
            make_snippet();
            while (byte_q.size() > 0) begin
               send(ACT_BYTE, byte_q.pop_front(), 0, 0, 0);
               sent++;
            end
         end
      end
      send(ACT_END, 8'h00, 0, 0, 0);
      req_valid <= 1'b0;

      // drain and let any late output show up
      wait_cnt = 0;
      while (token_q.size() > 0 && wait_cnt < 5000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && token_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
